FILE: src/agcl_pkg.sv
package agcl_pkg;

    // Default window length of the level detector.
    localparam int WINDOW_DEPTH_DEF = 32;

    // Q15 magnitude width and full-scale value.
    localparam int          Q15_W   = 15;
    localparam logic [14:0] Q15_ONE = 15'd32767;

    // Configuration port.
    localparam int CFG_IDX_W = 3;

    typedef enum logic [2:0] {
        REG_TARGET_LEVEL      = 3'd0,
        REG_MAX_GAIN          = 3'd1,
        REG_MIN_GAIN          = 3'd2,
        REG_ATTACK_COEFF      = 3'd3,
        REG_RELEASE_COEFF     = 3'd4,
        REG_LIMITER_ENABLE    = 3'd5,
        REG_LIMITER_THRESHOLD = 3'd6,
        REG_DETECTOR_MODE     = 3'd7
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [14:0] RST_TARGET_LEVEL      = 15'd3276;
    localparam logic [14:0] RST_MAX_GAIN          = 15'd32767;
    localparam logic [14:0] RST_MIN_GAIN          = 15'd10362;
    localparam logic [14:0] RST_ATTACK_COEFF      = 15'd204;
    localparam logic [14:0] RST_RELEASE_COEFF     = 15'd20;
    localparam logic        RST_LIMITER_ENABLE    = 1'b1;
    localparam logic [14:0] RST_LIMITER_THRESHOLD = 15'd23200;
    localparam logic        RST_DETECTOR_MODE     = 1'b1;

    // Detector mode codes.
    localparam logic MODE_PEAK = 1'b0;
    localparam logic MODE_RMS  = 1'b1;

    // Every serial unit runs fifteen steps, one result bit per step.
    localparam logic [3:0] LAST_STEP = 4'd14;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SQ_MUL,
        S_WIN_WR,
        S_SCAN,
        S_MEAN_DIV,
        S_ROOT,
        S_ENV_PREP,
        S_ENV_MUL,
        S_GAIN_SEL,
        S_GAIN_DIV,
        S_GAIN_PREP,
        S_GAIN_MUL,
        S_APPLY_MUL,
        S_LIM_SEL,
        S_LIM_DIV,
        S_LIM_MUL,
        S_FINISH
    } agcl_state_t;

endpackage

FILE: src/agcl_if.sv
interface agcl_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface agcl_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;
    logic        [14:0] applied_gain;
    logic               limited;

    modport source (output valid, output sample_out, output applied_gain, output limited,
                    input ready);
    modport sink   (input valid, input sample_out, input applied_gain, input limited,
                    output ready);
endinterface

FILE: src/automatic_gain_control_limiter.sv
// Each sample runs through the window scan and the fifteen-step serial multiply, divide
// and square-root units; peak mode skips the mean divide and square root, and the gain
// divide and the limiter are skipped when not needed. One sample is taken at a time: a
// new sample is accepted only after the last result has entered the output register.
// Reset (rst_n, asynchronous) restores the register defaults, clears the window valid bits
// so both windows read as zero, zeroes the envelope and sets the gain to unity.
module automatic_gain_control_limiter #(
    parameter int WINDOW_DEPTH = agcl_pkg::WINDOW_DEPTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    agcl_in_if.sink                          sample_ch,
    agcl_out_if.source                       result_ch,
    input  logic                             cfg_we,
    input  logic [agcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [agcl_pkg::Q15_W-1:0]       cfg_data
);
    import agcl_pkg::*;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = Q15_W + IDX_W;

    localparam logic [CNT_W-1:0] SCAN_END  = CNT_W'(WINDOW_DEPTH);
    localparam logic [IDX_W-1:0] POS_LAST  = IDX_W'(WINDOW_DEPTH - 1);
    localparam logic [14:0]      DEPTH_DEN = 15'(WINDOW_DEPTH);

    // Configuration registers.
    logic [14:0] target_reg, maxg_reg, ming_reg, att_reg, rel_reg, thr_reg;
    logic        lim_en_reg, mode_reg;

    // Control and datapath registers.
    agcl_state_t      state_reg, state_next;
    logic [3:0]       cnt_reg;
    logic [15:0]      mag_s_reg;
    logic             neg_s_reg;
    logic [14:0]      entry_reg;
    logic [IDX_W-1:0] pk_pos_reg, sq_pos_reg;
    logic [CNT_W-1:0] scan_idx_reg;
    logic             pend_reg;
    logic [SUM_W-1:0] acc_reg;
    logic [14:0]      level_reg, env_reg, gain_reg, wanted_reg;
    logic             up_reg;
    logic [15:0]      y_reg;
    logic             lim_reg;

    // Serial multiplier, divider and square-root registers.
    logic [15:0] mc_reg;
    logic [31:0] prod_reg;
    logic [14:0] rem_reg, quo_reg, den_reg;
    logic [29:0] sx_reg, sres_reg, sbit_reg;

    // Window stores.
    logic [14:0]             pk_mem [WINDOW_DEPTH];
    logic [14:0]             sq_mem [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] pk_vld_reg, sq_vld_reg;
    logic [14:0]             rd_data_reg;
    logic                    rd_vld_reg;

    // Output register.
    logic        out_valid_reg;
    logic [15:0] out_sample_reg;
    logic [14:0] out_gain_reg;
    logic        out_lim_reg;

    // Serial multiplier step: add the multiplicand under the low bit, shift right.
    logic [16:0] mul_sum;
    logic [31:0] mul_step;
    logic [30:0] prod_fin;
    logic [31:0] ceil_sum;
    logic [15:0] q_floor, q_ceil;
    always_comb
    begin
        mul_sum  = prod_reg[31:15] + (prod_reg[0] ? {1'b0, mc_reg} : 17'd0);
        mul_step = {1'b0, mul_sum, prod_reg[14:1]};
        prod_fin = mul_step[30:0];
        ceil_sum = {1'b0, prod_fin} + 32'd32767;
        q_floor  = prod_fin[30:15];
        q_ceil   = ceil_sum[30:15];
    end

    // Restoring divider step: one quotient bit per cycle.
    logic [15:0] div_try;
    logic        div_ge;
    logic [14:0] div_rem_n, div_quo_n;
    always_comb
    begin
        div_try   = {rem_reg, quo_reg[14]};
        div_ge    = div_try >= {1'b0, den_reg};
        div_rem_n = div_ge ? 15'(div_try - {1'b0, den_reg}) : div_try[14:0];
        div_quo_n = {quo_reg[13:0], div_ge};
    end

    // Square-root step: one result bit per cycle.
    logic [30:0] s_trial;
    logic        s_ge;
    logic [29:0] sx_n, sres_n;
    always_comb
    begin
        s_trial = {1'b0, sres_reg} + {1'b0, sbit_reg};
        s_ge    = {1'b0, sx_reg} >= s_trial;
        sx_n    = s_ge ? 30'({1'b0, sx_reg} - s_trial) : sx_reg;
        sres_n  = s_ge ? 30'({1'b0, sres_reg >> 1} + {1'b0, sbit_reg}) : (sres_reg >> 1);
    end

    // Derived values used by several states.
    logic [15:0] in_mag;
    logic [29:0] tgt_num, thr_num;
    logic        gain_sat;
    logic [15:0] y_neg16;
    logic [14:0] y_mag;
    logic [14:0] wanted_clamp;
    logic [14:0] scan_val;
    logic        unit_last, scan_done, lim_hit;
    always_comb
    begin
        in_mag    = sample_ch.sample_in[15] ? 16'(~sample_ch.sample_in + 16'd1)
                                            : sample_ch.sample_in;
        tgt_num   = {target_reg, 15'd0} - {15'd0, target_reg};
        thr_num   = {thr_reg, 15'd0} - {15'd0, thr_reg};
        gain_sat  = tgt_num >= {env_reg, 15'd0};
        y_neg16   = 16'(~y_reg + 16'd1);
        y_mag     = y_reg[15] ? y_neg16[14:0] : y_reg[14:0];
        wanted_clamp = (wanted_reg > maxg_reg) ? maxg_reg : wanted_reg;
        if (wanted_clamp < ming_reg)
        begin
            wanted_clamp = ming_reg;
        end
        scan_val  = rd_vld_reg ? rd_data_reg : 15'd0;
        unit_last = cnt_reg == LAST_STEP;
        scan_done = (scan_idx_reg == SCAN_END) && !pend_reg;
        lim_hit   = lim_en_reg && (y_mag > thr_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:      if (sample_ch.valid) state_next = (mode_reg == MODE_RMS) ? S_SQ_MUL
                                                                               : S_WIN_WR;
            S_SQ_MUL:    if (unit_last) state_next = S_WIN_WR;
            S_WIN_WR:    state_next = S_SCAN;
            S_SCAN:      if (scan_done) state_next = (mode_reg == MODE_RMS) ? S_MEAN_DIV
                                                                           : S_ENV_PREP;
            S_MEAN_DIV:  if (unit_last) state_next = S_ROOT;
            S_ROOT:      if (unit_last) state_next = S_ENV_PREP;
            S_ENV_PREP:  state_next = S_ENV_MUL;
            S_ENV_MUL:   if (unit_last) state_next = S_GAIN_SEL;
            S_GAIN_SEL:  state_next = ((env_reg == 15'd0) || gain_sat) ? S_GAIN_PREP
                                                                        : S_GAIN_DIV;
            S_GAIN_DIV:  if (unit_last) state_next = S_GAIN_PREP;
            S_GAIN_PREP: state_next = S_GAIN_MUL;
            S_GAIN_MUL:  if (unit_last) state_next = S_APPLY_MUL;
            S_APPLY_MUL: if (unit_last) state_next = S_LIM_SEL;
            S_LIM_SEL:   state_next = lim_hit ? S_LIM_DIV : S_FINISH;
            S_LIM_DIV:   if (unit_last) state_next = S_LIM_MUL;
            S_LIM_MUL:   if (unit_last) state_next = S_FINISH;
            S_FINISH:    if (!out_valid_reg || result_ch.ready) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers; writes beyond a register's width drop the upper bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg <= RST_TARGET_LEVEL;
            maxg_reg   <= RST_MAX_GAIN;
            ming_reg   <= RST_MIN_GAIN;
            att_reg    <= RST_ATTACK_COEFF;
            rel_reg    <= RST_RELEASE_COEFF;
            lim_en_reg <= RST_LIMITER_ENABLE;
            thr_reg    <= RST_LIMITER_THRESHOLD;
            mode_reg   <= RST_DETECTOR_MODE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_TARGET_LEVEL:      target_reg <= cfg_data;
                REG_MAX_GAIN:          maxg_reg   <= cfg_data;
                REG_MIN_GAIN:          ming_reg   <= cfg_data;
                REG_ATTACK_COEFF:      att_reg    <= cfg_data;
                REG_RELEASE_COEFF:     rel_reg    <= cfg_data;
                REG_LIMITER_ENABLE:    lim_en_reg <= cfg_data[0];
                REG_LIMITER_THRESHOLD: thr_reg    <= cfg_data;
                REG_DETECTOR_MODE:     mode_reg   <= cfg_data[0];
                default:               ;
            endcase
        end
    end

    // Window stores: written once per sample, read one entry per cycle during the scan.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WIN_WR)
        begin
            if (mode_reg == MODE_RMS)
            begin
                sq_mem[sq_pos_reg] <= entry_reg;
            end
            else
            begin
                pk_mem[pk_pos_reg] <= entry_reg;
            end
        end
        if (state_reg == S_SCAN && scan_idx_reg != SCAN_END)
        begin
            rd_data_reg <= (mode_reg == MODE_RMS) ? sq_mem[scan_idx_reg[IDX_W-1:0]]
                                                  : pk_mem[scan_idx_reg[IDX_W-1:0]];
        end
    end

    // Window valid bits and write positions; an entry not yet written reads as zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pk_vld_reg <= '0;
            sq_vld_reg <= '0;
            pk_pos_reg <= '0;
            sq_pos_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_WIN_WR)
            begin
                if (mode_reg == MODE_RMS)
                begin
                    sq_vld_reg[sq_pos_reg] <= 1'b1;
                    sq_pos_reg <= (sq_pos_reg == POS_LAST) ? '0 : sq_pos_reg + 1'b1;
                end
                else
                begin
                    pk_vld_reg[pk_pos_reg] <= 1'b1;
                    pk_pos_reg <= (pk_pos_reg == POS_LAST) ? '0 : pk_pos_reg + 1'b1;
                end
            end
            if (state_reg == S_SCAN && scan_idx_reg != SCAN_END)
            begin
                rd_vld_reg <= (mode_reg == MODE_RMS) ? sq_vld_reg[scan_idx_reg[IDX_W-1:0]]
                                                     : pk_vld_reg[scan_idx_reg[IDX_W-1:0]];
            end
        end
    end

    // Step counter of the serial units.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (state_reg == S_SQ_MUL || state_reg == S_MEAN_DIV || state_reg == S_ROOT ||
                 state_reg == S_ENV_MUL || state_reg == S_GAIN_DIV ||
                 state_reg == S_GAIN_MUL || state_reg == S_APPLY_MUL ||
                 state_reg == S_LIM_DIV || state_reg == S_LIM_MUL)
        begin
            cnt_reg <= unit_last ? 4'd0 : cnt_reg + 4'd1;
        end
        else
        begin
            cnt_reg <= '0;
        end
    end

    // Envelope, gain and scan bookkeeping.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            env_reg      <= '0;
            gain_reg     <= Q15_ONE;
            scan_idx_reg <= '0;
            pend_reg     <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_WIN_WR:
                begin
                    scan_idx_reg <= '0;
                    pend_reg     <= 1'b0;
                end
                S_SCAN:
                begin
                    pend_reg <= scan_idx_reg != SCAN_END;
                    if (scan_idx_reg != SCAN_END)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                end
                S_ENV_MUL:
                begin
                    if (unit_last)
                    begin
                        env_reg <= up_reg ? env_reg + prod_fin[29:15]
                                          : env_reg - prod_fin[29:15];
                    end
                end
                S_GAIN_MUL:
                begin
                    if (unit_last)
                    begin
                        gain_reg <= up_reg ? gain_reg + prod_fin[29:15]
                                           : gain_reg - prod_fin[29:15];
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath of the serial units and the per-sample values.
    logic [14:0] gain_new;
    logic [15:0] sgn_q, y_val;
    logic        y_neg;
    always_comb
    begin
        gain_new = up_reg ? gain_reg + prod_fin[29:15] : gain_reg - prod_fin[29:15];
        y_neg    = (state_reg == S_LIM_MUL) ? y_reg[15] : neg_s_reg;
        sgn_q    = y_neg ? q_ceil : q_floor;
        y_val    = y_neg ? 16'(~sgn_q + 16'd1) : sgn_q;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                mag_s_reg <= in_mag;
                neg_s_reg <= sample_ch.sample_in[15];
                entry_reg <= in_mag[15] ? Q15_ONE : in_mag[14:0];
                mc_reg    <= in_mag;
                prod_reg  <= {17'd0, (in_mag[15] ? Q15_ONE : in_mag[14:0])};
            end
            S_SQ_MUL:
            begin
                prod_reg <= mul_step;
                if (unit_last)
                begin
                    entry_reg <= q_floor[15] ? Q15_ONE : q_floor[14:0];
                end
            end
            S_WIN_WR:
            begin
                acc_reg <= '0;
            end
            S_SCAN:
            begin
                if (pend_reg)
                begin
                    if (mode_reg == MODE_RMS)
                    begin
                        acc_reg <= acc_reg + SUM_W'(scan_val);
                    end
                    else if (SUM_W'(scan_val) > acc_reg)
                    begin
                        acc_reg <= SUM_W'(scan_val);
                    end
                end
                if (scan_done)
                begin
                    level_reg <= acc_reg[14:0];
                    rem_reg   <= 15'(30'(acc_reg) >> 15);
                    quo_reg   <= acc_reg[14:0];
                    den_reg   <= DEPTH_DEN;
                end
            end
            S_MEAN_DIV:
            begin
                rem_reg <= div_rem_n;
                quo_reg <= div_quo_n;
                if (unit_last)
                begin
                    sx_reg   <= {div_quo_n, 15'd0};
                    sres_reg <= '0;
                    sbit_reg <= 30'h1000_0000;
                end
            end
            S_ROOT:
            begin
                sx_reg   <= sx_n;
                sres_reg <= sres_n;
                sbit_reg <= sbit_reg >> 2;
                if (unit_last)
                begin
                    level_reg <= sres_n[14:0];
                end
            end
            S_ENV_PREP:
            begin
                up_reg   <= level_reg > env_reg;
                mc_reg   <= {1'b0, (level_reg > env_reg) ? level_reg - env_reg
                                                         : env_reg - level_reg};
                prod_reg <= {17'd0, (level_reg > env_reg) ? att_reg : rel_reg};
            end
            S_ENV_MUL:
            begin
                prod_reg <= mul_step;
            end
            S_GAIN_SEL:
            begin
                wanted_reg <= (env_reg == 15'd0) ? maxg_reg : Q15_ONE;
                rem_reg    <= tgt_num[29:15];
                quo_reg    <= tgt_num[14:0];
                den_reg    <= env_reg;
            end
            S_GAIN_DIV:
            begin
                rem_reg <= div_rem_n;
                quo_reg <= div_quo_n;
                if (unit_last)
                begin
                    wanted_reg <= div_quo_n;
                end
            end
            S_GAIN_PREP:
            begin
                up_reg   <= wanted_clamp > gain_reg;
                mc_reg   <= {1'b0, (wanted_clamp > gain_reg) ? wanted_clamp - gain_reg
                                                             : gain_reg - wanted_clamp};
                prod_reg <= {17'd0, (wanted_clamp > gain_reg) ? att_reg : rel_reg};
            end
            S_GAIN_MUL:
            begin
                prod_reg <= mul_step;
                if (unit_last)
                begin
                    mc_reg   <= mag_s_reg;
                    prod_reg <= {17'd0, gain_new};
                end
            end
            S_APPLY_MUL:
            begin
                prod_reg <= mul_step;
                if (unit_last)
                begin
                    y_reg   <= y_val;
                    lim_reg <= 1'b0;
                end
            end
            S_LIM_SEL:
            begin
                rem_reg <= thr_num[29:15];
                quo_reg <= thr_num[14:0];
                den_reg <= y_mag;
            end
            S_LIM_DIV:
            begin
                rem_reg <= div_rem_n;
                quo_reg <= div_quo_n;
                if (unit_last)
                begin
                    mc_reg   <= {1'b0, y_mag};
                    prod_reg <= {17'd0, div_quo_n};
                end
            end
            S_LIM_MUL:
            begin
                prod_reg <= mul_step;
                if (unit_last)
                begin
                    y_reg   <= y_val;
                    lim_reg <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Output register: loaded when the result slot is free or being emptied.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_FINISH && (!out_valid_reg || result_ch.ready))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FINISH && (!out_valid_reg || result_ch.ready))
        begin
            out_sample_reg <= y_reg;
            out_gain_reg   <= gain_reg;
            out_lim_reg    <= lim_reg;
        end
    end

    assign sample_ch.ready        = state_reg == S_IDLE;
    assign result_ch.valid        = out_valid_reg;
    assign result_ch.sample_out   = out_sample_reg;
    assign result_ch.applied_gain = out_gain_reg;
    assign result_ch.limited      = out_lim_reg;

    // The block stays busy for the sample it has just taken.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (sample_ch.valid && sample_ch.ready) |=> !sample_ch.ready)
        else $error("input taken again while a sample is in work");

    // The divider remainder always stays below the divisor.
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MEAN_DIV || state_reg == S_GAIN_DIV || state_reg == S_LIM_DIV)
        |-> (rem_reg < den_reg))
        else $error("divider remainder not below divisor");

    // The scan never runs past the end of the window.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (scan_idx_reg <= SCAN_END))
        else $error("window scan index out of range");

    // A finished result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result_ch.ready && state_reg == S_FINISH)
        |=> (state_reg == S_FINISH))
        else $error("result dropped while output stalled");

endmodule

FILE: sim/agc_checker.sv
`timescale 1ns / 100ps

// Watches both channels and the configuration port, predicts every result
// of the gain controller and compares it with what comes out.
module agc_checker (
    input  logic clk,
    input  logic rst_n,
    agcl_in_if   sample_ch,
    agcl_out_if  result_ch,
    input  logic                           cfg_we,
    input  logic [agcl_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [agcl_pkg::Q15_W-1:0]     cfg_data,
    output int                             pending,
    output int                             fail_count
);
    import agcl_pkg::*;

    localparam int DEPTH = WINDOW_DEPTH_DEF;
    localparam int FULL  = 32767;

    typedef struct {
        logic signed [15:0] sample_out;
        logic        [14:0] applied_gain;
        logic               limited;
    } agc_result_t;

    agc_result_t gain_results_q[$];

    // Shadow of the configuration registers.
    int tgt_lvl, gain_hi, gain_lo, rise_rate, fall_rate;
    int lim_thresh;
    logic limiter_enable, detector_mode;

    // Shadow of the detector and smoothing state.
    int peak_win[DEPTH];
    int square_win[DEPTH];
    int peak_pos, square_pos;
    int envelope, gain;

    // Q15 product, rounded toward minus infinity and saturated.
    function automatic int q15_mul(input int a, input int b);
        longint prod;
        longint q;
        prod = longint'(a) * longint'(b);
        q = prod >>> 15;
        if (q > FULL) q = FULL;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    function automatic int abs_q15(input int v);
        if (v < 0)
            return (-v > FULL) ? FULL : -v;
        return v;
    endfunction

    function automatic int int_sqrt(input int unsigned x);
        int unsigned res;
        int unsigned bitv;
        res = 0;
        bitv = 32'd1 << 30;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return int'(res);
    endfunction

    // Move a value toward its goal with separate rise and fall rates.
    function automatic int track(input int value, input int goal, input int up, input int down);
        if (goal > value)
            return value + q15_mul(goal - value, up);
        return value - q15_mul(value - goal, down);
    endfunction

    function automatic agc_result_t predict_gain_step(input logic signed [15:0] s_in);
        agc_result_t r;
        int s, level, wanted, y, m, g;
        int unsigned sum;
        s = s_in;
        level = 0;
        r.limited = 1'b0;
        if (detector_mode == MODE_PEAK)
        begin
            peak_win[peak_pos] = abs_q15(s);
            peak_pos = (peak_pos + 1) % DEPTH;
            foreach (peak_win[i])
                if (peak_win[i] > level) level = peak_win[i];
        end
        else
        begin
            sum = 0;
            square_win[square_pos] = q15_mul(s, s);
            square_pos = (square_pos + 1) % DEPTH;
            foreach (square_win[i]) sum += square_win[i];
            level = int_sqrt((sum / DEPTH) << 15);
            if (level > FULL) level = FULL;
        end
        envelope = track(envelope, level, rise_rate, fall_rate);
        if (envelope > 0)
        begin
            wanted = (tgt_lvl * FULL) / envelope;
            if (wanted > FULL) wanted = FULL;
        end
        else
            wanted = gain_hi;
        if (wanted > gain_hi) wanted = gain_hi;
        if (wanted < gain_lo) wanted = gain_lo;
        gain = track(gain, wanted, rise_rate, fall_rate);
        y = q15_mul(s, gain);
        if (limiter_enable)
        begin
            m = abs_q15(y);
            if (m > lim_thresh)
            begin
                g = (lim_thresh * FULL) / m;
                y = q15_mul(y, g);
                r.limited = 1'b1;
            end
        end
        r.sample_out = y[15:0];
        r.applied_gain = gain[14:0];
        return r;
    endfunction

    // Mirror writes, predict on input transactions, compare on output transactions.
    always @(posedge clk or negedge rst_n)
    begin
        agc_result_t exp_r;
        if (!rst_n)
        begin
            tgt_lvl = RST_TARGET_LEVEL;
            gain_hi = RST_MAX_GAIN;
            gain_lo = RST_MIN_GAIN;
            rise_rate = RST_ATTACK_COEFF;
            fall_rate = RST_RELEASE_COEFF;
            limiter_enable = RST_LIMITER_ENABLE;
            lim_thresh = RST_LIMITER_THRESHOLD;
            detector_mode = RST_DETECTOR_MODE;
            foreach (peak_win[i]) peak_win[i] = 0;
            foreach (square_win[i]) square_win[i] = 0;
            peak_pos = 0;
            square_pos = 0;
            envelope = 0;
            gain = FULL;
            gain_results_q.delete();
            pending = 0;
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_TARGET_LEVEL:      tgt_lvl = cfg_data;
                    REG_MAX_GAIN:          gain_hi = cfg_data;
                    REG_MIN_GAIN:          gain_lo = cfg_data;
                    REG_ATTACK_COEFF:      rise_rate = cfg_data;
                    REG_RELEASE_COEFF:     fall_rate = cfg_data;
                    REG_LIMITER_ENABLE:    limiter_enable = cfg_data[0];
                    REG_LIMITER_THRESHOLD: lim_thresh = cfg_data;
                    REG_DETECTOR_MODE:     detector_mode = cfg_data[0];
                    default: ;
                endcase
            end
            if (result_ch.valid && result_ch.ready)
            begin
                if (gain_results_q.size() == 0)
                begin
                    $display("%0t: unexpected result transaction out=%0d gain=%0d lim=%0b",
                             $time, result_ch.sample_out, result_ch.applied_gain,
                             result_ch.limited);
                    fail_count++;
                end
                else
                begin
                    exp_r = gain_results_q.pop_front();
                    if (result_ch.sample_out !== exp_r.sample_out)
                    begin
                        $display("%0t: sample_out expected %0d actual %0d", $time,
                                 exp_r.sample_out, result_ch.sample_out);
                        fail_count++;
                    end
                    if (result_ch.applied_gain !== exp_r.applied_gain)
                    begin
                        $display("%0t: applied_gain expected %0d actual %0d", $time,
                                 exp_r.applied_gain, result_ch.applied_gain);
                        fail_count++;
                    end
                    if (result_ch.limited !== exp_r.limited)
                    begin
                        $display("%0t: limited expected %0b actual %0b", $time,
                                 exp_r.limited, result_ch.limited);
                        fail_count++;
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready)
                gain_results_q.push_back(predict_gain_step(sample_ch.sample_in));
            pending = gain_results_q.size();
        end
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import agcl_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASES = 8;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [Q15_W-1:0] cfg_data;
    int pending;
    int fail_count;
    int idle_cycles;
    int cycle_no;
    int stall_style;
    int gap_style;
    bit hold_request;

    agcl_in_if  sample_ch ();
    agcl_out_if result_ch ();

    automatic_gain_control_limiter u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    agc_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_ch  (sample_ch),
        .result_ch  (result_ch),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .pending    (pending),
        .fail_count (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Receiver: stall pattern per phase, plus one long hold-off on request.
    initial
    begin
        result_ch.ready <= 1'b0;
        cycle_no = 0;
        forever
        begin
            @(posedge clk);
            cycle_no++;
            if (hold_request)
            begin
                result_ch.ready <= 1'b0;
                repeat (900) @(posedge clk);
                hold_request = 1'b0;
            end
            else if (!rst_n)
                result_ch.ready <= 1'b0;
            else
            begin
                case (stall_style)
                    0: result_ch.ready <= 1'b1;
                    1: result_ch.ready <= ($urandom_range(0, 1) == 1);
                    default: result_ch.ready <= ((cycle_no % 41) < 23);
                endcase
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
            cfg_we || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_sample(input logic signed [15:0] v);
        sample_ch.valid <= 1'b1;
        sample_ch.sample_in <= v;
        do @(posedge clk); while (!sample_ch.ready);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [14:0] d);
        cfg_we <= 1'b1;
        cfg_index <= r;
        cfg_data <= d;
        @(posedge clk);
    endtask

    // Lets the block drain before the registers change.
    task automatic drain();
        sample_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [14:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 15'd0;
            1: return 15'd32767;
            2: return 15'($urandom_range(0, 600));
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic logic signed [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 16'($urandom_range(0, 65535));
            4, 5, 6: return 16'(int'($urandom_range(0, 1024)) - 512);
            7, 8: return 16'(int'($urandom_range(0, 8192)) - 4096);
            default: return ($urandom_range(0, 1) == 1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    // Bursts of samples with random gaps between them; gap_style zero sends one unbroken burst.
    task automatic send_random(input int count);
        int burst, gap;
        while (count > 0)
        begin
            burst = (gap_style == 0) ? count : $urandom_range(1, 20);
            if (burst > count) burst = count;
            repeat (burst) send_sample(pick_sample());
            count -= burst;
            if (gap_style != 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 250)
                                                  : $urandom_range(0, 5);
                if (gap > 0)
                begin
                    sample_ch.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    task automatic send_directed();
        logic signed [15:0] pattern[$];
        pattern = '{16'sh0000, 16'sh7fff, 16'sh8000, 16'shffff, 16'sh0001, 16'sh4000,
                    16'shc000, 16'sh8000, 16'sh7fff, 16'sh8001, 16'sh0000, 16'sh0000,
                    16'sh0010, 16'shfff0, 16'sh5555, 16'shaaaa, 16'sh7fff, 16'sh7fff,
                    16'sh7fff, 16'sh0000};
        foreach (pattern[i]) send_sample(pattern[i]);
    endtask

    initial
    begin
        cfg_reg_t r;
        rst_n <= 1'b0;
        sample_ch.valid <= 1'b0;
        sample_ch.sample_in <= '0;
        cfg_we <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        idle_cycles = 0;
        hold_request = 1'b0;
        stall_style = 0;
        gap_style = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (4) @(posedge clk);

        // Reset settings in RMS mode, then peak mode, with extreme samples.
        send_directed();
        drain();
        write_reg(REG_DETECTOR_MODE, 15'h7ffe);
        cfg_we <= 1'b0;
        send_directed();
        drain();

        // Zero attack rate, min above max and a tight limiter.
        write_reg(REG_ATTACK_COEFF, 15'd0);
        write_reg(REG_MIN_GAIN, 15'd30000);
        write_reg(REG_MAX_GAIN, 15'd1000);
        write_reg(REG_LIMITER_THRESHOLD, 15'd0);
        cfg_we <= 1'b0;
        send_directed();
        drain();

        // Large ratio and fast attack, limiter off.
        write_reg(REG_TARGET_LEVEL, 15'd32767);
        write_reg(REG_ATTACK_COEFF, 15'd32767);
        write_reg(REG_RELEASE_COEFF, 15'd32767);
        write_reg(REG_MIN_GAIN, 15'd0);
        write_reg(REG_MAX_GAIN, 15'd32767);
        write_reg(REG_LIMITER_ENABLE, 15'h0002);
        cfg_we <= 1'b0;
        send_directed();
        drain();

        // Random phases, the first two with all registers at full scale and then at zero.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            stall_style = ph % 3;
            gap_style = (ph % 4 == 0) ? 0 : 1;
            for (int k = 0; k < 8; k++)
            begin
                r = cfg_reg_t'(k);
                if (ph == 0)
                    write_reg(r, 15'd32767);
                else if (ph == 1)
                    write_reg(r, 15'd0);
                else if (r == REG_LIMITER_ENABLE || r == REG_DETECTOR_MODE)
                    write_reg(r, 15'($urandom_range(0, 32767)));
                else
                    write_reg(r, pick_value());
            end
            cfg_we <= 1'b0;
            if (ph == 3)
                hold_request = 1'b1;
            send_random(180);
            drain();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
